// ===== rtl/core/kcp_pkg.sv =====
package kcp_pkg;

  localparam int unsigned KEY_BYTES = 16;

  localparam logic [5:0] PREFIX_LEN = 6'd6;
  localparam logic [5:0] SEP_POS    = 6'(PREFIX_LEN + 2 * KEY_BYTES);
  localparam logic [5:0] TEXT_LEN   = SEP_POS + 6'd9;
  localparam logic [5:0] LAST_POS   = TEXT_LEN - 6'd1;
  localparam logic [5:0] POS_MAX    = 6'd63;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [7:0]  SCHEMA_BYTE = 8'h01;
  localparam logic [7:0]  SEP_CHAR    = 8'h2D;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LENGTH   = 3'd1;
  localparam logic [2:0] ST_PREFIX   = 3'd2;
  localparam logic [2:0] ST_KEY_HEX  = 3'd3;
  localparam logic [2:0] ST_ZERO_KEY = 3'd4;
  localparam logic [2:0] ST_CRC_HEX  = 3'd5;
  localparam logic [2:0] ST_CRC_BAD  = 3'd6;

  // Error flag bits.
  localparam int unsigned ERR_PREFIX = 0;
  localparam int unsigned ERR_KEYHEX = 1;
  localparam int unsigned ERR_CRCHEX = 2;

  typedef struct packed {
    logic       text_end;
    logic [7:0] text_char;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
  } result_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_RESET = crc_byte(CRC_INIT, SCHEMA_BYTE);

  // Upper bit set means the character is not an uppercase hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39)      d = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) d = {1'b0, 4'(c - 8'h37)};
    else                               d = 5'h10;
    return d;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h4C;
      3'd2:    c = 8'h43;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h31;
      3'd5:    c = 8'h2D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/kcp_parser.sv =====
module kcp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  kcp_pkg::item_t  item,
  output kcp_pkg::result_t result
);
  import kcp_pkg::*;

  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] key_hi_r, key_hi_nxt;
  logic [63:0] key_lo_r, key_lo_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        knz_r, knz_nxt;

  logic [4:0]  hex;
  logic [3:0]  dig;
  logic [5:0]  k;
  logic [7:0]  kbyte;

  assign hex   = hex_digit(item.text_char);
  assign dig   = hex[4] ? 4'd0 : hex[3:0];
  assign k     = pos_r - PREFIX_LEN;
  assign kbyte = {nib_r, dig};

  always_comb begin
    pos_nxt    = pos_r;
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    nib_nxt    = nib_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    err_nxt    = err_r;
    knz_nxt    = knz_r;
    if (pos_r < PREFIX_LEN) begin
      if (item.text_char != prefix_char(pos_r[2:0])) err_nxt[ERR_PREFIX] = 1'b1;
    end else if (pos_r < SEP_POS) begin
      if (hex[4]) err_nxt[ERR_KEYHEX] = 1'b1;
      if (!k[0]) begin
        nib_nxt = dig;
      end else begin
        // Byte index bit 3 selects the upper or the lower key word.
        if (!k[4]) key_hi_nxt = {key_hi_r[55:0], kbyte};
        else       key_lo_nxt = {key_lo_r[55:0], kbyte};
        crc_nxt = crc_byte(crc_r, kbyte);
        if (kbyte != 8'd0) knz_nxt = 1'b1;
      end
    end else if (pos_r == SEP_POS) begin
      if (item.text_char != SEP_CHAR) err_nxt[ERR_PREFIX] = 1'b1;
    end else if (pos_r < TEXT_LEN) begin
      if (hex[4]) err_nxt[ERR_CRCHEX] = 1'b1;
      rcrc_nxt = {rcrc_r[27:0], dig};
    end
    if (pos_r < POS_MAX) pos_nxt = pos_r + 6'd1;
  end

  // The verdict looks at the state including the final character.
  always_comb begin
    if (pos_r != LAST_POS)         result.status = ST_LENGTH;
    else if (err_nxt[ERR_PREFIX])  result.status = ST_PREFIX;
    else if (err_nxt[ERR_KEYHEX])  result.status = ST_KEY_HEX;
    else if (!knz_nxt)             result.status = ST_ZERO_KEY;
    else if (err_nxt[ERR_CRCHEX])  result.status = ST_CRC_HEX;
    else if (~crc_nxt != rcrc_nxt) result.status = ST_CRC_BAD;
    else                           result.status = ST_OK;
    result.key_upper = (result.status == ST_OK) ? key_hi_nxt : 64'd0;
    result.key_lower = (result.status == ST_OK) ? key_lo_nxt : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.text_end)) begin
      pos_r    <= 6'd0;
      key_hi_r <= 64'd0;
      key_lo_r <= 64'd0;
      nib_r    <= 4'd0;
      crc_r    <= CRC_RESET;
      rcrc_r   <= 32'd0;
      err_r    <= 3'd0;
      knz_r    <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      key_hi_r <= key_hi_nxt;
      key_lo_r <= key_lo_nxt;
      nib_r    <= nib_nxt;
      crc_r    <= crc_nxt;
      rcrc_r   <= rcrc_nxt;
      err_r    <= err_nxt;
      knz_r    <= knz_nxt;
    end
  end

endmodule

// ===== rtl/core/key_text_checksum_parser_core.sv =====
// Channel | Direction | Beat content
// in_     | input     | tdata[7:0] one text character; tlast marks the last character
// out_    | output    | one verdict beat per text: status, upper and lower key halves
//
// One character beat is taken every clock cycle, unless a last character waits in the
// input register for the result slot. A verdict reaches out_tvalid by way of the input
// register and then the parse stage that loads the result register. Reset (rst_n low,
// synchronous) empties both registers and returns the parser to position zero with the
// CRC preloaded with the schema byte. A stalled result only holds back a following last
// character; ordinary characters keep flowing underneath it.
module key_text_checksum_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] text_char
  input  logic         in_tlast,   // text_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // [2:0] status, [66:3] key_upper, [130:67] key_lower
);
  import kcp_pkg::*;

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t verdict;
  logic    out_free;
  logic    proc_fire;

  // A character leaves the input register when it needs no result slot, or the slot
  // is free or being emptied this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign proc_fire = in_valid_r && (!in_item_r.text_end || out_free);
  assign in_tready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.text_char <= in_tdata;
      in_item_r.text_end  <= in_tlast;
    end
  end

  kcp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (proc_fire),
    .item   (in_item_r),
    .result (verdict)
  );

  // Result register: loaded only by the last character of a text.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && in_item_r.text_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_item_r.text_end) begin
      out_res_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.key_lower, out_res_r.key_upper, out_res_r.status};

`ifndef SYNTHESIS
  // A rejected text never exposes key material.
  a_key_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ST_OK |->
      out_res_r.key_upper == 64'd0 && out_res_r.key_lower == 64'd0)
    else $error("key bits present with a failing status");

  // A held character is not dropped from the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !proc_fire |=> in_valid_r && $stable(in_item_r))
    else $error("input register lost a waiting character");

  // The result register only fills from a last character.
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r && in_item_r.text_end))
    else $error("verdict appeared without a last character");
`endif

endmodule
